// ----- sv/vpl_pkg.sv -----
package vpl_pkg;

    localparam int unsigned ADDR_W     = 14;
    localparam int unsigned VRAM_DEPTH = 1 << ADDR_W;
    localparam int unsigned NUM_REGS   = 11;

    localparam logic [7:0] HEIGHT_SMALL  = 8'd192;
    localparam logic [7:0] HEIGHT_MEDIUM = 8'd224;
    localparam logic [7:0] HEIGHT_LARGE  = 8'd240;
    localparam logic [7:0] JUMP_FROM     = 8'd218;
    localparam logic [7:0] JUMP_TO       = 8'd213;

    typedef enum logic [2:0] {
        MODE_CTRL_WR   = 3'd0,
        MODE_DATA_WR   = 3'd1,
        MODE_DATA_RD   = 3'd2,
        MODE_STATUS_RD = 3'd3,
        MODE_VCOUNT_RD = 3'd4,
        MODE_LINE_TICK = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        CODE_VRAM_RD = 2'd0,
        CODE_VRAM_WR = 2'd1,
        CODE_REG_WR  = 2'd2,
        CODE_CRAM_WR = 2'd3
    } code_t;

    localparam logic [3:0] REG_MODE0 = 4'd0;
    localparam logic [3:0] REG_MODE1 = 4'd1;
    localparam logic [3:0] REG_LINE  = 4'd10;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } vram_req_t;

    typedef struct packed {
        logic [7:0] mode0;
        logic [7:0] mode1;
        logic [7:0] line_reload;
    } timing_cfg_t;

    typedef struct packed {
        logic       vblank_set;
        logic       frame_set;
        logic       line_int;
        logic       render_valid;
        logic [7:0] render_line;
    } tick_evt_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       frame_irq;
        logic       color_written;
        logic [4:0] color_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } port_result_t;

    function automatic logic [7:0] chan_expand(input logic [1:0] c);
        return {c, c, c, c};
    endfunction

endpackage

// ----- sv/video_port_and_line_timing.sv -----
// video_port_and_line_timing
// host port and line timing of a tile video chip
// input channel (in_valid/in_ready) carries one port transaction: mode selects
// control write, data write, data read, status read, vertical counter read or
// line tick, and wdata is the byte for writes
// output channel (out_valid/out_ready) returns exactly one result per input
// transaction, in order: read byte, irq after a line tick, colour write report
// with expanded channels, and the active line to render
// the result is registered and valid in the cycle after the input is taken
// throughput: one transaction per cycle while not stalled and not clearing; the
// video ram is a single-port memory with at most one access per transaction, read
// data registered and used by a later data read through the prefetch buffer
// reset: all control state clears, then a sweep writes zero to all 16384 video
// ram entries, one per cycle; in_ready stays low until the sweep is done
// stall: the output register holds its result while out_ready is low, and a
// new input transaction is taken in the same cycle the held result leaves
module video_port_and_line_timing (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] mode,
    input  logic [7:0] wdata,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] rdata,
    output logic       irq,
    output logic       color_written,
    output logic [4:0] color_index,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic       render_valid,
    output logic [7:0] render_line
);

    logic                  accept;
    logic                  is_tick;
    logic                  vram_ready;
    logic [7:0]            ram_q;
    logic [7:0]            vcount;
    vpl_pkg::vram_req_t    req;
    vpl_pkg::timing_cfg_t  cfg;
    vpl_pkg::tick_evt_t    evt;
    vpl_pkg::port_result_t res;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    vpl_pkg::port_result_t res_reg;
    logic                  line_int_reg;
    logic                  render_valid_reg;
    logic [7:0]            render_line_reg;

    assign in_ready = vram_ready && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign is_tick  = (mode == vpl_pkg::MODE_LINE_TICK);

    vpl_vram u_vram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .q     (ram_q),
        .ready (vram_ready)
    );

    vpl_line_timing u_timing (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (accept && is_tick),
        .cfg    (cfg),
        .evt    (evt),
        .vcount (vcount)
    );

    vpl_host_port u_port (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .mode   (mode),
        .wdata  (wdata),
        .evt    (evt),
        .vcount (vcount),
        .ram_q  (ram_q),
        .req    (req),
        .cfg    (cfg),
        .res    (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg          <= res;
            line_int_reg     <= is_tick && evt.line_int;
            render_valid_reg <= is_tick && evt.render_valid;
            render_line_reg  <= is_tick ? evt.render_line : 8'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign rdata         = res_reg.rdata;
    assign irq           = res_reg.frame_irq || line_int_reg;
    assign color_written = res_reg.color_written;
    assign color_index   = res_reg.color_index;
    assign red           = res_reg.red;
    assign green         = res_reg.green;
    assign blue          = res_reg.blue;
    assign render_valid  = render_valid_reg;
    assign render_line   = render_line_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !vram_ready |-> !accept)
        else $error("transaction taken during video ram clear");

    a_status_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode == vpl_pkg::MODE_STATUS_RD |=> rdata[4:0] == 5'd0)
        else $error("status read returned low bits");

    a_color_not_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && color_written |-> !render_valid && !irq && rdata == 8'd0)
        else $error("colour write result mixed with tick fields");

    a_valid_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(accept))
        else $error("result appeared without an input transaction");

endmodule

// ----- sv/vpl_vram.sv -----
module vpl_vram (
    input  logic                clk,
    input  logic                rst_n,
    input  vpl_pkg::vram_req_t  req,
    output logic [7:0]          q,
    output logic                ready
);

    logic [7:0] mem [vpl_pkg::VRAM_DEPTH];

    logic                       clr_busy_reg;
    logic                       clr_busy_next;
    logic [vpl_pkg::ADDR_W-1:0] clr_addr_reg;
    logic [vpl_pkg::ADDR_W-1:0] clr_addr_next;
    logic [7:0]                 q_reg;

    // zero sweep after reset
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + {{(vpl_pkg::ADDR_W-1){1'b0}}, 1'b1};
            if (&clr_addr_reg)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= 8'd0;
        end
        else if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            q_reg <= mem[req.addr];
        end
    end

    assign q     = q_reg;
    assign ready = !clr_busy_reg;

endmodule

// ----- sv/vpl_line_timing.sv -----
module vpl_line_timing (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  vpl_pkg::timing_cfg_t cfg,
    output vpl_pkg::tick_evt_t   evt,
    output logic [7:0]           vcount
);

    logic [7:0] vc_reg;
    logic [7:0] vc_next;
    logic       jumped_reg;
    logic       jumped_next;
    logic [7:0] ldc_reg;
    logic [7:0] ldc_next;
    logic [7:0] height_reg;
    logic [7:0] height_next;
    logic       active;

    assign active = vc_reg < height_reg;

    always_comb
    begin
        evt         = '0;
        ldc_next    = ldc_reg;
        height_next = height_reg;
        evt.render_valid = active;
        evt.render_line  = active ? vc_reg : 8'd0;
        if (active)
        begin
            if (ldc_reg == 8'd0)
            begin
                ldc_next     = cfg.line_reload;
                evt.line_int = cfg.mode0[4];
            end
            else
            begin
                ldc_next = ldc_reg - 8'd1;
            end
        end
        else
        begin
            if (vc_reg == height_reg)
            begin
                evt.vblank_set = 1'b1;
                evt.frame_set  = cfg.mode1[5];
                ldc_next       = cfg.line_reload;
            end
            if (cfg.mode0[2] && cfg.mode0[1])
            begin
                if (cfg.mode1[3])
                begin
                    height_next = vpl_pkg::HEIGHT_LARGE;
                end
                else if (cfg.mode1[4])
                begin
                    height_next = vpl_pkg::HEIGHT_MEDIUM;
                end
                else
                begin
                    height_next = vpl_pkg::HEIGHT_SMALL;
                end
            end
            else
            begin
                height_next = vpl_pkg::HEIGHT_SMALL;
            end
        end
    end

    // vertical counter with one jump per frame
    always_comb
    begin
        vc_next     = vc_reg + 8'd1;
        jumped_next = jumped_reg;
        if (vc_reg == 8'hFF)
        begin
            vc_next     = 8'd0;
            jumped_next = 1'b0;
        end
        else if (vc_reg == vpl_pkg::JUMP_FROM && !jumped_reg)
        begin
            vc_next     = vpl_pkg::JUMP_TO;
            jumped_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg     <= 8'd0;
            jumped_reg <= 1'b0;
            ldc_reg    <= 8'hFF;
            height_reg <= vpl_pkg::HEIGHT_SMALL;
        end
        else if (tick)
        begin
            vc_reg     <= vc_next;
            jumped_reg <= jumped_next;
            ldc_reg    <= ldc_next;
            height_reg <= height_next;
        end
    end

    assign vcount = vc_reg;

endmodule

// ----- sv/vpl_host_port.sv -----
module vpl_host_port (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [2:0]            mode,
    input  logic [7:0]            wdata,
    input  vpl_pkg::tick_evt_t    evt,
    input  logic [7:0]            vcount,
    input  logic [7:0]            ram_q,
    output vpl_pkg::vram_req_t    req,
    output vpl_pkg::timing_cfg_t  cfg,
    output vpl_pkg::port_result_t res
);

    logic [7:0]  regs_reg [vpl_pkg::NUM_REGS];
    logic [15:0] cmd_reg;
    logic [15:0] cmd_next;
    logic        second_reg;
    logic        second_next;
    logic [7:0]  rb_reg;
    logic [7:0]  rb_next;
    logic        rb_ram_reg;
    logic        rb_ram_next;
    logic        vblank_reg;
    logic        vblank_next;
    logic        pending_reg;
    logic        pending_next;
    logic        reg_we;
    logic [3:0]  reg_idx;

    logic [vpl_pkg::ADDR_W-1:0] addr;
    logic [vpl_pkg::ADDR_W-1:0] ctrl_addr;
    logic [7:0]                 rb_eff;
    vpl_pkg::code_t             code;
    vpl_pkg::code_t             new_code;

    assign addr      = cmd_reg[vpl_pkg::ADDR_W-1:0];
    assign ctrl_addr = {wdata[5:0], cmd_reg[7:0]};
    assign code      = vpl_pkg::code_t'(cmd_reg[15:14]);
    assign new_code  = vpl_pkg::code_t'(wdata[7:6]);
    assign rb_eff    = rb_ram_reg ? ram_q : rb_reg;
    assign reg_idx   = wdata[3:0];

    always_comb
    begin
        cmd_next     = cmd_reg;
        second_next  = second_reg;
        rb_next      = rb_reg;
        rb_ram_next  = rb_ram_reg;
        vblank_next  = vblank_reg;
        pending_next = pending_reg;
        reg_we       = 1'b0;
        req          = '0;
        req.addr     = addr;
        req.wdata    = wdata;
        res          = '0;
        unique case (vpl_pkg::mode_t'(mode))
            vpl_pkg::MODE_CTRL_WR:
            begin
                if (!second_reg)
                begin
                    cmd_next[7:0] = wdata;
                    second_next   = 1'b1;
                end
                else
                begin
                    cmd_next[15:8] = wdata;
                    second_next    = 1'b0;
                    if (new_code == vpl_pkg::CODE_VRAM_RD)
                    begin
                        req.rd_en   = 1'b1;
                        req.addr    = ctrl_addr;
                        rb_ram_next = 1'b1;
                        cmd_next[vpl_pkg::ADDR_W-1:0] =
                            ctrl_addr + {{(vpl_pkg::ADDR_W-1){1'b0}}, 1'b1};
                    end
                    else if (new_code == vpl_pkg::CODE_REG_WR)
                    begin
                        if (reg_idx < 4'(vpl_pkg::NUM_REGS))
                        begin
                            reg_we = 1'b1;
                            if (reg_idx == vpl_pkg::REG_MODE1 && vblank_reg && cmd_reg[5])
                            begin
                                pending_next = 1'b1;
                            end
                        end
                    end
                end
            end
            vpl_pkg::MODE_DATA_WR:
            begin
                second_next = 1'b0;
                if (code == vpl_pkg::CODE_CRAM_WR)
                begin
                    res.color_written = 1'b1;
                    res.color_index   = addr[4:0];
                    res.red           = vpl_pkg::chan_expand(wdata[1:0]);
                    res.green         = vpl_pkg::chan_expand(wdata[3:2]);
                    res.blue          = vpl_pkg::chan_expand(wdata[5:4]);
                end
                else
                begin
                    req.wr_en = 1'b1;
                end
                rb_next     = wdata;
                rb_ram_next = 1'b0;
                cmd_next[vpl_pkg::ADDR_W-1:0] = addr + {{(vpl_pkg::ADDR_W-1){1'b0}}, 1'b1};
            end
            vpl_pkg::MODE_DATA_RD:
            begin
                second_next = 1'b0;
                res.rdata   = rb_eff;
                req.rd_en   = 1'b1;
                rb_ram_next = 1'b1;
                cmd_next[vpl_pkg::ADDR_W-1:0] = addr + {{(vpl_pkg::ADDR_W-1){1'b0}}, 1'b1};
            end
            vpl_pkg::MODE_STATUS_RD:
            begin
                res.rdata    = {vblank_reg, 7'd0};
                vblank_next  = 1'b0;
                pending_next = 1'b0;
                second_next  = 1'b0;
            end
            vpl_pkg::MODE_VCOUNT_RD:
            begin
                res.rdata = vcount;
            end
            vpl_pkg::MODE_LINE_TICK:
            begin
                if (evt.vblank_set)
                begin
                    vblank_next = 1'b1;
                end
                if (evt.frame_set)
                begin
                    pending_next = 1'b1;
                end
                res.frame_irq = pending_next;
            end
            default:
            begin
            end
        endcase
        if (!accept)
        begin
            req.rd_en = 1'b0;
            req.wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= 16'd0;
            second_reg  <= 1'b0;
            rb_reg      <= 8'd0;
            rb_ram_reg  <= 1'b0;
            vblank_reg  <= 1'b0;
            pending_reg <= 1'b0;
            for (int i = 0; i < vpl_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= 8'd0;
            end
        end
        else if (accept)
        begin
            cmd_reg     <= cmd_next;
            second_reg  <= second_next;
            rb_reg      <= rb_next;
            rb_ram_reg  <= rb_ram_next;
            vblank_reg  <= vblank_next;
            pending_reg <= pending_next;
            if (reg_we)
            begin
                regs_reg[reg_idx] <= cmd_reg[7:0];
            end
        end
    end

    assign cfg.mode0       = regs_reg[vpl_pkg::REG_MODE0];
    assign cfg.mode1       = regs_reg[vpl_pkg::REG_MODE1];
    assign cfg.line_reload = regs_reg[vpl_pkg::REG_LINE];

endmodule

// ----- dv/vpl_tb_pkg.sv -----
`timescale 1ns / 100ps
package vpl_tb_pkg;

    import vpl_pkg::*;

    localparam logic [3:0] REG_SCROLL = 4'd9;
    localparam logic [3:0] REG_TOP    = 4'd15;

    // mode values the block leaves unused
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic       color_written;
        logic [4:0] color_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       render_valid;
        logic [7:0] render_line;
    } port_result_s;

    class vdp_port_scoreboard;
        logic [7:0]   vram [VRAM_DEPTH];
        logic [7:0]   cram [32];
        logic [7:0]   regs [NUM_REGS];
        logic [15:0]  cmd;
        logic         second;
        logic [7:0]   rbuf;
        logic [7:0]   status;
        logic         frame_pend;
        logic [7:0]   line_cnt;
        logic [7:0]   vcount;
        logic         jumped;
        logic [7:0]   height;
        logic [7:0]   scroll;
        port_result_s expected_results [$];
        int unsigned  mismatches;
        int unsigned  checked;

        function new();
            foreach (vram[i])
                vram[i] = '0;
            foreach (cram[i])
                cram[i] = '0;
            foreach (regs[i])
                regs[i] = '0;
            cmd        = '0;
            second     = 1'b0;
            rbuf       = '0;
            status     = '0;
            frame_pend = 1'b0;
            line_cnt   = 8'hFF;
            vcount     = '0;
            jumped     = 1'b0;
            height     = HEIGHT_SMALL;
            scroll     = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // work out the result of one accepted transaction and queue it
        function void note_transaction(logic [2:0] op, logic [7:0] wbyte);
            port_result_s r;
            logic [13:0]  addr;
            code_t        code;
            logic [3:0]   idx;
            logic [7:0]   vc;
            logic         fired;
            r     = '0;
            addr  = cmd[13:0];
            code  = code_t'(cmd[15:14]);
            fired = 1'b0;
            case (op)
                MODE_CTRL_WR:
                begin
                    if (!second)
                    begin
                        cmd[7:0] = wbyte;
                        second   = 1'b1;
                    end
                    else
                    begin
                        cmd[15:8] = wbyte;
                        second    = 1'b0;
                        case (code_t'(cmd[15:14]))
                            CODE_VRAM_RD:
                            begin
                                rbuf       = vram[cmd[13:0]];
                                cmd[13:0]  = cmd[13:0] + 14'd1;
                            end
                            CODE_REG_WR:
                            begin
                                idx = cmd[11:8];
                                if (idx < NUM_REGS)
                                begin
                                    regs[idx] = cmd[7:0];
                                    // frame interrupt enabled while vblank flag is up
                                    if (idx == REG_MODE1 && status[7] && cmd[5])
                                        frame_pend = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                MODE_DATA_WR:
                begin
                    second = 1'b0;
                    if (code == CODE_CRAM_WR)
                    begin
                        cram[addr[4:0]] = wbyte;
                        r.color_written = 1'b1;
                        r.color_index   = addr[4:0];
                        r.red           = 8'd85 * wbyte[1:0];
                        r.green         = 8'd85 * wbyte[3:2];
                        r.blue          = 8'd85 * wbyte[5:4];
                    end
                    else
                        vram[addr] = wbyte;
                    rbuf      = wbyte;
                    cmd[13:0] = addr + 14'd1;
                end
                MODE_DATA_RD:
                begin
                    second    = 1'b0;
                    r.rdata   = rbuf;
                    rbuf      = vram[addr];
                    cmd[13:0] = addr + 14'd1;
                end
                MODE_STATUS_RD:
                begin
                    r.rdata    = status;
                    status     = status & 8'h1F;
                    second     = 1'b0;
                    frame_pend = 1'b0;
                end
                MODE_VCOUNT_RD:
                    r.rdata = vcount;
                MODE_LINE_TICK:
                begin
                    vc = vcount;
                    if (vc < height)
                    begin
                        r.render_valid = 1'b1;
                        r.render_line  = vc;
                        if (line_cnt == 8'd0)
                        begin
                            line_cnt = regs[REG_LINE];
                            if (regs[REG_MODE0][4])
                                fired = 1'b1;
                        end
                        else
                            line_cnt = line_cnt - 8'd1;
                    end
                    else
                    begin
                        if (vc == height)
                        begin
                            status[7] = 1'b1;
                            if (regs[REG_MODE1][5])
                            begin
                                frame_pend = 1'b1;
                                fired      = 1'b1;
                            end
                            line_cnt = regs[REG_LINE];
                        end
                        scroll = regs[REG_SCROLL];
                        if (regs[REG_MODE0][2] && regs[REG_MODE0][1])
                            height = regs[REG_MODE1][3] ? HEIGHT_LARGE :
                                     regs[REG_MODE1][4] ? HEIGHT_MEDIUM : HEIGHT_SMALL;
                        else
                            height = HEIGHT_SMALL;
                    end
                    if (vc == 8'hFF)
                    begin
                        vcount = 8'd0;
                        jumped = 1'b0;
                    end
                    else if (vc == JUMP_FROM && !jumped)
                    begin
                        vcount = JUMP_TO;
                        jumped = 1'b1;
                    end
                    else
                        vcount = vc + 8'd1;
                    r.irq = fired | frame_pend;
                end
                default: ;
            endcase
            expected_results.push_back(r);
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            mismatches++;
            $display("result %0d: %s got 'h%0h expected 'h%0h", checked, what, got, want);
        endtask

        task check_transaction(port_result_s got);
            port_result_s want;
            checked++;
            if (expected_results.size() == 0)
            begin
                report("unexpected result, rdata", got.rdata, 8'h00);
                return;
            end
            want = expected_results.pop_front();
            if (got.rdata !== want.rdata)
                report("rdata", got.rdata, want.rdata);
            if (got.irq !== want.irq)
                report("irq", got.irq, want.irq);
            if (got.color_written !== want.color_written)
                report("color_written", got.color_written, want.color_written);
            if (got.color_index !== want.color_index)
                report("color_index", got.color_index, want.color_index);
            if (got.red !== want.red)
                report("red", got.red, want.red);
            if (got.green !== want.green)
                report("green", got.green, want.green);
            if (got.blue !== want.blue)
                report("blue", got.blue, want.blue);
            if (got.render_valid !== want.render_valid)
                report("render_valid", got.render_valid, want.render_valid);
            if (got.render_line !== want.render_line)
                report("render_line", got.render_line, want.render_line);
        endtask
    endclass

endpackage

// ----- dv/video_port_and_line_timing_tb.sv -----
`timescale 1ns / 100ps
module video_port_and_line_timing_tb;

    import vpl_pkg::*;
    import vpl_tb_pkg::*;

    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned TOTAL_ITEMS = 1150;
    localparam int unsigned CALM_AFTER  = 1000;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] mode;
    logic [7:0] wdata;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] rdata;
    logic       irq;
    logic       color_written;
    logic [4:0] color_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       render_valid;
    logic [7:0] render_line;

    vdp_port_scoreboard sb;
    int unsigned        items_sent = 0;
    int unsigned        gap_odds   = 8;
    int unsigned        stall_odds = 8;
    bit                 calm       = 1'b0;
    int unsigned        cycle_count;

    video_port_and_line_timing i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .wdata         (wdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rdata         (rdata),
        .irq           (irq),
        .color_written (color_written),
        .color_index   (color_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .render_valid  (render_valid),
        .render_line   (render_line)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic send(input logic [2:0] op, input logic [7:0] wbyte);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        wdata    <= wbyte;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_transaction(op, wbyte);
        if (op <= MODE_LINE_TICK)
            items_sent++;
    endtask

    // low byte first, then the byte carrying the code
    task automatic write_ctrl(input logic [15:0] word);
        send(MODE_CTRL_WR, word[7:0]);
        send(MODE_CTRL_WR, word[15:8]);
    endtask

    task automatic set_reg(input logic [3:0] idx, input logic [7:0] val);
        write_ctrl({CODE_REG_WR, 2'($urandom), idx, val});
    endtask

    // input is already idle when nothing is outstanding
    task automatic drain_pause();
        if (sb.expected_results.size() != 0)
        begin
            in_valid <= 1'b0;
            while (sb.expected_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_transaction({rdata, irq, color_written, color_index, red, green, blue,
                                  render_valid, render_line});
    end

    // receiver stalls
    initial
    begin
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** video_port_and_line_timing: FAILED **");
        $finish;
    end

    initial
    begin
        int unsigned sel;
        logic [13:0] addr;
        logic [7:0]  val;
        logic [3:0]  idx;

        sb = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        mode     <= MODE_CTRL_WR;
        wdata    <= 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset values, address wrap, prefetch, colour writes, register edge cases
        send(MODE_STATUS_RD, 8'h00);
        send(MODE_VCOUNT_RD, 8'hFF);
        send(MODE_DATA_RD, 8'h00);
        write_ctrl({CODE_VRAM_WR, 14'h3FFF});
        send(MODE_DATA_WR, 8'hFF);
        send(MODE_DATA_WR, 8'h00);
        write_ctrl({CODE_VRAM_RD, 14'h3FFF});
        send(MODE_DATA_RD, 8'h5A);
        write_ctrl({CODE_CRAM_WR, 14'h001F});
        send(MODE_DATA_WR, 8'h39);
        send(MODE_DATA_WR, 8'hC6);
        set_reg(REG_TOP, 8'hAA);
        set_reg(REG_MODE1, 8'h20);
        // lone control byte, then a status read drops the half command
        send(MODE_CTRL_WR, 8'h55);
        send(MODE_STATUS_RD, 8'h00);
        send(MODE_SPARE_A, 8'hFF);
        send(MODE_SPARE_B, 8'h00);
        send(MODE_LINE_TICK, 8'h00);
        drain_pause();

        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= CALM_AFTER)
            begin
                gap_odds = 0;
                calm     = 1'b1;
            end
            else if ($urandom_range(0, 24) == 0)
            begin
                gap_odds   = $urandom_range(0, 2) * 5;
                stall_odds = $urandom_range(0, 2) * 5;
            end
            if (!calm && $urandom_range(0, 59) == 0)
                drain_pause();

            sel = $urandom_range(0, 99);
            if (sel < 38)
            begin
                repeat ($urandom_range(1, 60))
                    send(MODE_LINE_TICK, 8'($urandom));
            end
            else if (sel < 52)
            begin
                val = 8'($urandom);
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        idx = REG_MODE0;
                        if ($urandom_range(0, 1) == 1)
                            val[2:1] = 2'b11;
                    end
                    2, 3: idx = REG_MODE1;
                    4: idx = REG_SCROLL;
                    5, 6:
                    begin
                        idx = REG_LINE;
                        if ($urandom_range(0, 1) == 1)
                            val = 8'($urandom_range(0, 7));
                    end
                    7, 8: idx = 4'($urandom_range(0, NUM_REGS - 1));
                    default: idx = 4'($urandom_range(NUM_REGS, REG_TOP));
                endcase
                set_reg(idx, val);
            end
            else if (sel < 70 || sel >= 86 && sel < 92)
            begin
                if (sel < 70)
                begin
                    case ($urandom_range(0, 3))
                        0: addr = 14'($urandom_range(0, 63));
                        1: addr = 14'h3FFF - 14'($urandom_range(0, 7));
                        default: addr = 14'($urandom);
                    endcase
                    write_ctrl({code_t'($urandom_range(0, 3)), addr});
                end
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 4) < 3)
                        send(MODE_DATA_WR, 8'($urandom));
                    else
                        send(MODE_DATA_RD, 8'($urandom));
                end
            end
            else if (sel < 80)
                send(MODE_STATUS_RD, 8'($urandom));
            else if (sel < 86)
                send(MODE_VCOUNT_RD, 8'($urandom));
            else if (sel < 97)
                send(MODE_CTRL_WR, 8'($urandom));
            else
                send($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B, 8'($urandom));
        end

        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("** video_port_and_line_timing: PASSED **");
        else
            $display("** video_port_and_line_timing: FAILED **");
        $finish;
    end

endmodule
